// File: rtl/core/utf8nv_pkg.sv
// ----------------------------------------------------------------------------
// utf8nv_pkg
// Shared types, constants and decode helpers for the UTF-8 name validator.
// ----------------------------------------------------------------------------
package utf8nv_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned CODE_W  = 21;

    localparam logic [BYTE_W-1:0]  LIMIT_RESET = 8'd64;

    localparam logic [CODE_W-1:0]  CODE_MAX      = 21'h10FFFF;
    localparam logic [CODE_W-1:0]  SURR_LO       = 21'h00D800;
    localparam logic [CODE_W-1:0]  SURR_HI       = 21'h00DFFF;
    localparam logic [CODE_W-1:0]  CTRL_LIMIT    = 21'h000020;
    localparam logic [CODE_W-1:0]  CODE_DEL      = 21'h00007F;

    // Sequence length classes; class_minimum gives the smallest code point each may legally encode.
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_TWO   = 2'd1,
        CLS_THREE = 2'd2,
        CLS_FOUR  = 2'd3
    } seq_class_t;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic [1:0]         pending;
        logic [CODE_W-1:0]  partial;
        seq_class_t         min_class;
        logic               error_seen;
        logic               first_done;
        logic               first_is_space;
        logic               last_is_space;
    } name_state_t;

    localparam name_state_t NAME_STATE_CLEAR = '{
        byte_count:     '0,
        pending:        '0,
        partial:        '0,
        min_class:      CLS_NONE,
        error_seen:     1'b0,
        first_done:     1'b0,
        first_is_space: 1'b0,
        last_is_space:  1'b0
    };

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              has_byte;
        logic              last;
    } name_item_t;

    function automatic logic [CODE_W-1:0] class_minimum(input seq_class_t cls);
        logic [CODE_W-1:0] lo;
        case (cls)
            CLS_NONE:  lo = 21'h000000;
            CLS_TWO:   lo = 21'h000080;
            CLS_THREE: lo = 21'h000800;
            CLS_FOUR:  lo = 21'h010000;
            default:   lo = 21'h000000;
        endcase
        return lo;
    endfunction

    function automatic logic is_space(input logic [CODE_W-1:0] c);
        logic sp;
        case (c) inside
            21'h000020, 21'h0000A0, 21'h001680,
            [21'h002000:21'h00200A],
            21'h002028, 21'h002029, 21'h00202F,
            21'h00205F, 21'h003000, 21'h00FEFF: sp = 1'b1;
            default:                            sp = 1'b0;
        endcase
        return sp;
    endfunction

endpackage

// File: rtl/core/utf8_name_validator.sv
// ----------------------------------------------------------------------------
// utf8_name_validator
// Strict UTF-8 name checker that takes at most one byte per item and gives a verdict per name.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, set by the state update loop, while no verdict
// is left waiting. A closing item is taken by the input register, and its
// verdict then by the result register, which drives m_tvalid.
// A verdict left waiting holds the next closing item, and with it the input.
// Reset: rst_n is asynchronous and active low; it empties both registers,
// clears all name state and sets the length limit back to 64 bytes.
// ----------------------------------------------------------------------------
module utf8_name_validator (
    input  logic       clk,
    input  logic       rst_n,

    // Length limit register.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,     // [7:0] name_limit

    // Incoming name bytes.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] byte_value
    input  logic [0:0] s_tuser,      // [0] has_byte
    input  logic       s_tlast,      // last

    // Verdicts, one per name.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata       // [0] name_ok, [7:1] zero
);
    import utf8nv_pkg::*;

    logic [7:0]  limit_reg;
    name_item_t  item_reg;
    logic        item_valid_reg;
    logic        item_valid_next;
    name_state_t state_reg;
    name_state_t state_next;
    logic        verdict;
    logic        out_free;
    logic        fire;

    // The limit register is to be written only between names, which the block
    // does not enforce; cfg_ready is tied high, so it can always take a write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid)
        begin
            limit_reg <= cfg_data;
        end
    end

    // The registered item is retired when it produces no verdict, or when the
    // result register has room for its verdict. Only a closing item stalls.
    assign fire     = item_valid_reg && (!item_reg.last || out_free);
    assign s_tready = !item_valid_reg || fire;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (s_tready)
        begin
            item_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.byte_value <= s_tdata;
            item_reg.has_byte   <= s_tuser[0];
            item_reg.last       <= s_tlast;
        end
    end

    // Decode the registered byte against the running name state. A closing
    // item computes its verdict from the updated state and then clears it.
    utf8nv_step u_step (
        .state_cur  (state_reg),
        .item       (item_reg),
        .name_limit (limit_reg),
        .state_next (state_next),
        .name_ok    (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= NAME_STATE_CLEAR;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    utf8nv_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (fire && item_reg.last),
        .ok_in    (verdict),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTH
    // A retired closing item always leaves a verdict waiting downstream.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item_reg.last) |=> m_tvalid)
        else $error("closing item retired without a verdict");

    // An open multi-byte sequence always carries its minimum class.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.pending != 2'd0) |-> (state_reg.min_class != CLS_NONE))
        else $error("open sequence without a length class");

    // The space flags are only ever set once a first code point exists.
    assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.first_done |-> (!state_reg.last_is_space && !state_reg.first_is_space))
        else $error("space flag set before any code point");
`endif

endmodule

// File: rtl/core/utf8nv_step.sv
// ----------------------------------------------------------------------------
// utf8nv_step
// One byte of decode: next name state and the verdict for a closing item.
// ----------------------------------------------------------------------------
module utf8nv_step (
    input  utf8nv_pkg::name_state_t state_cur,
    input  utf8nv_pkg::name_item_t  item,
    input  logic [7:0]              name_limit,
    output utf8nv_pkg::name_state_t state_next,
    output logic                    name_ok
);
    import utf8nv_pkg::*;

    always_comb
    begin
        name_state_t       s;
        logic              fin;
        logic [CODE_W-1:0] code;
        seq_class_t        cls_used;
        logic [BYTE_W-1:0] b;

        s        = state_cur;
        fin      = 1'b0;
        code     = '0;
        cls_used = CLS_NONE;
        b        = item.byte_value;

        if (item.has_byte)
        begin
            if (s.byte_count <= {1'b0, name_limit})
            begin
                s.byte_count = s.byte_count + 9'd1;
            end

            if (s.pending != 2'd0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    // A lead or ASCII byte where a continuation was due.
                    s.error_seen = 1'b1;
                    s.pending    = 2'd0;
                    s.partial    = '0;
                    s.min_class  = CLS_NONE;
                end
                else
                begin
                    s.partial = {s.partial[CODE_W-7:0], b[5:0]};
                    s.pending = s.pending - 2'd1;
                    if (s.pending == 2'd0)
                    begin
                        fin      = 1'b1;
                        code     = s.partial;
                        cls_used = s.min_class;
                    end
                end
            end
            else
            begin
                case (b) inside
                    [8'h00:8'h7F]:
                    begin
                        fin  = 1'b1;
                        code = {13'd0, b};
                    end
                    [8'hC2:8'hDF]:
                    begin
                        s.pending   = 2'd1;
                        s.partial   = {16'd0, b[4:0]};
                        s.min_class = CLS_TWO;
                    end
                    [8'hE0:8'hEF]:
                    begin
                        s.pending   = 2'd2;
                        s.partial   = {17'd0, b[3:0]};
                        s.min_class = CLS_THREE;
                    end
                    [8'hF0:8'hF4]:
                    begin
                        s.pending   = 2'd3;
                        s.partial   = {18'd0, b[2:0]};
                        s.min_class = CLS_FOUR;
                    end
                    default:
                    begin
                        s.error_seen = 1'b1;
                    end
                endcase
            end

            if (fin)
            begin
                if (code < class_minimum(cls_used) || code > CODE_MAX ||
                    (code >= SURR_LO && code <= SURR_HI) ||
                    code < CTRL_LIMIT || code == CODE_DEL)
                begin
                    s.error_seen = 1'b1;
                end
                if (!s.first_done)
                begin
                    s.first_done     = 1'b1;
                    s.first_is_space = is_space(code);
                end
                s.last_is_space = is_space(code);
                s.min_class     = CLS_NONE;
                s.partial       = '0;
            end
        end

        name_ok = !s.error_seen && (s.byte_count != 9'd0) &&
                  (s.byte_count <= {1'b0, name_limit}) &&
                  (s.pending == 2'd0) && s.first_done &&
                  !s.first_is_space && !s.last_is_space;

        state_next = item.last ? NAME_STATE_CLEAR : s;
    end

endmodule

// File: rtl/core/utf8nv_out.sv
// ----------------------------------------------------------------------------
// utf8nv_out
// Result register holding one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module utf8nv_out (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic       ok_in,
    output logic       free,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata     // [0] name_ok, [7:1] zero
);
    logic valid_reg;
    logic valid_next;
    logic ok_reg;

    // The slot can take a new verdict when empty or being drained this cycle.
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg <= ok_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, ok_reg};

endmodule

// File: sim/utf8_name_checker.sv
// ----------------------------------------------------------------------------
// utf8_name_checker
// Follows the limit, byte and verdict channels of the name validator. It
// decodes the accepted bytes on its own and compares each verdict with the
// oldest one it has worked out.
// ----------------------------------------------------------------------------
module utf8_name_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] byte_value
    input  logic [0:0] s_tuser,      // [0] has_byte
    input  logic       s_tlast,      // last
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,      // [0] name_ok, [7:1] zero
    output int         mismatch_count,
    output int         verdicts_waiting,
    output int         verdicts_checked,
    output int         verdicts_valid
);
    timeunit 1ns;
    timeprecision 1ps;

    import utf8nv_pkg::*;

    logic [7:0]  limit_model;
    name_state_t scan;
    logic        verdict_queue[$];

    task automatic note_mismatch(input string what);
        $display("%0t ns  name verdict: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic blank_code(input logic [CODE_W-1:0] c);
        return c == 21'h000020 || c == 21'h0000A0 || c == 21'h001680 ||
               (c >= 21'h002000 && c <= 21'h00200A) ||
               c == 21'h002028 || c == 21'h002029 || c == 21'h00202F ||
               c == 21'h00205F || c == 21'h003000 || c == 21'h00FEFF;
    endfunction

    // A code point is complete: judge it against the floor of its sequence
    // length and the forbidden ranges, then track the whitespace at both ends.
    function automatic void close_code_point(input logic [CODE_W-1:0] cp);
        logic [CODE_W-1:0] floor_cp;
        case (scan.min_class)
            CLS_TWO:   floor_cp = 21'h000080;
            CLS_THREE: floor_cp = 21'h000800;
            CLS_FOUR:  floor_cp = 21'h010000;
            default:   floor_cp = '0;
        endcase
        if (cp < floor_cp || cp > CODE_MAX || (cp >= SURR_LO && cp <= SURR_HI) ||
            cp < CTRL_LIMIT || cp == CODE_DEL)
            scan.error_seen = 1'b1;
        if (!scan.first_done)
        begin
            scan.first_done     = 1'b1;
            scan.first_is_space = blank_code(cp);
        end
        scan.last_is_space = blank_code(cp);
        scan.min_class     = CLS_NONE;
        scan.partial       = '0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        // The count stops one past the limit.
        if (scan.byte_count <= {1'b0, limit_model})
            scan.byte_count = scan.byte_count + 9'd1;

        if (scan.pending != 2'd0)
        begin
            if (b[7:6] != 2'b10)
            begin
                // The offending byte is dropped along with the open sequence.
                scan.error_seen = 1'b1;
                scan.pending    = 2'd0;
                scan.partial    = '0;
                scan.min_class  = CLS_NONE;
            end
            else
            begin
                scan.partial = {scan.partial[CODE_W-7:0], b[5:0]};
                scan.pending = scan.pending - 2'd1;
                if (scan.pending == 2'd0)
                    close_code_point(scan.partial);
            end
        end
        else if (b < 8'h80)
        begin
            scan.min_class = CLS_NONE;
            close_code_point({13'd0, b});
        end
        else if (b >= 8'hC2 && b <= 8'hDF)
        begin
            scan.pending   = 2'd1;
            scan.partial   = {16'd0, b[4:0]};
            scan.min_class = CLS_TWO;
        end
        else if (b >= 8'hE0 && b <= 8'hEF)
        begin
            scan.pending   = 2'd2;
            scan.partial   = {17'd0, b[3:0]};
            scan.min_class = CLS_THREE;
        end
        else if (b >= 8'hF0 && b <= 8'hF4)
        begin
            scan.pending   = 2'd3;
            scan.partial   = {18'd0, b[2:0]};
            scan.min_class = CLS_FOUR;
        end
        else
        begin
            scan.error_seen = 1'b1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic want;
        logic ok_model;
        if (!rst_n)
        begin
            limit_model = LIMIT_RESET;
            scan        = NAME_STATE_CLEAR;
            verdict_queue.delete();
            mismatch_count   = 0;
            verdicts_waiting = 0;
            verdicts_checked = 0;
            verdicts_valid   = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    note_mismatch($sformatf("tdata %02h arrived with no name closed",
                                            m_tdata));
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (m_tdata !== {7'd0, want})
                        note_mismatch($sformatf("name %0d: tdata %02h, name_ok should be %0d",
                                                verdicts_checked, m_tdata, want));
                    verdicts_checked++;
                    if (want)
                        verdicts_valid++;
                end
            end

            if (cfg_valid && cfg_ready)
                limit_model = cfg_data;

            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0])
                    absorb_byte(s_tdata);
                if (s_tlast)
                begin
                    ok_model = !scan.error_seen && scan.byte_count != '0 &&
                               scan.byte_count <= {1'b0, limit_model} &&
                               scan.pending == 2'd0 && scan.first_done &&
                               !scan.first_is_space && !scan.last_is_space;
                    verdict_queue = {verdict_queue, ok_model};
                    scan = NAME_STATE_CLEAR;
                end
            end

            verdicts_waiting = verdict_queue.size();
        end
    end

endmodule

// File: sim/utf8_name_validator_test.sv
// ----------------------------------------------------------------------------
// utf8_name_validator_test
// Drives names into the UTF-8 name validator under several length limits and
// lets the checker beside the block judge every verdict. A directed set of
// names comes first, then randomly built names that are mostly well formed
// with one fault planted in some of them.
// ----------------------------------------------------------------------------
module utf8_name_validator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8nv_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    // Generous ceiling: every item waiting out the longest gap and the longest
    // verdict stall would still finish well inside it.
    localparam int CYCLE_LIMIT   = 400000;
    // The verdict reaches the output through the input register and then the
    // result register; the settle time also covers a name that was closed by an
    // item carrying no byte.
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 7;

    // Whitespace code points that may not open or close a name.
    localparam logic [20:0] BLANKS [12] = '{
        21'h000020, 21'h0000A0, 21'h001680, 21'h002000, 21'h002005, 21'h00200A,
        21'h002028, 21'h002029, 21'h00202F, 21'h00205F, 21'h003000, 21'h00FEFF
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] cfg_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic [0:0] s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    int mismatch_count;
    int verdicts_waiting;
    int verdicts_checked;
    int verdicts_valid;

    // Percent chance that an item is held back by a gap; zero turns idling off.
    int         idle_pct;
    logic [7:0] limit_now;
    int         bytes_sent;
    int         names_sent;
    int         limits_tried;
    int         cycle_count;

    utf8_name_validator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    utf8_name_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatch_count   (mismatch_count),
        .verdicts_waiting (verdicts_waiting),
        .verdicts_checked (verdicts_checked),
        .verdicts_valid   (verdicts_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The verdict side stalls in bursts. The chance per cycle is kept lower than
    // on the byte side, since every cycle gets a roll here.
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_pct != 0 && $urandom_range(0, 399) < idle_pct)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Watchdog: a run that hangs ends here as a failure.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles, %0d verdicts still awaited",
                 cycle_count, verdicts_waiting);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ---------------------------------------------------------------- drivers

    // Offers one item and returns at the edge where it is taken. A gap, when
    // rolled, drops tvalid first; otherwise tvalid stays high back to back.
    task automatic push_item(input logic [7:0] b, input logic has, input logic fin);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= has;
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
    endtask

    // Sends one name. Now and then an item with no byte and no end mark is
    // slipped in, which the block must ignore, and sometimes the name is
    // closed by a separate item that carries no byte. An empty name is just
    // that closing item.
    task automatic send_name(input byte_q_t q);
        logic split_end;
        split_end = (q.size() == 0) || ($urandom_range(0, 5) == 0);
        foreach (q[i])
        begin
            if ($urandom_range(0, 19) == 0)
                push_item(8'($urandom), 1'b0, 1'b0);
            push_item(q[i], 1'b1, !split_end && i == q.size() - 1);
            bytes_sent++;
        end
        if (split_end)
            push_item(8'($urandom), 1'b0, 1'b1);
        names_sent++;
    endtask

    task automatic load_limit(input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_now = v;
        limits_tried++;
    endtask

    // Waits until every closed name has its verdict, then lets the pipeline
    // settle so that a limit write finds the block idle.
    task automatic drain_verdicts();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (verdicts_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // -------------------------------------------------------------- name build

    // Encodes a code point in n bytes; n of zero picks the shortest form, a
    // larger n gives an overlong form.
    function automatic byte_q_t encode(input logic [20:0] cp, input int n);
        byte_q_t b;
        int      len;
        len = n;
        if (len <= 0)
            len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
        case (len)
            1: b = '{cp[7:0]};
            2: b = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}};
            3: b = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
            default: b = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
                           {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
        endcase
        return b;
    endfunction

    // Code point of any sequence length, never a surrogate; one-byte ones are printable ASCII.
    function automatic logic [20:0] pick_glyph();
        logic [20:0] cp;
        do
        begin
            case ($urandom_range(0, 3))
                0:       cp = 21'($urandom_range(21'h21, 21'h7E));
                1:       cp = 21'($urandom_range(21'h80, 21'h7FF));
                2:       cp = 21'($urandom_range(21'h800, 21'hFFFF));
                default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
            endcase
        end
        while (cp >= SURR_LO && cp <= SURR_HI);
        return cp;
    endfunction

    function automatic byte_q_t splice(input byte_q_t q, input byte_q_t part);
        int pos;
        pos = $urandom_range(0, q.size());
        for (int i = part.size() - 1; i >= 0; i--)
            q.insert(pos, part[i]);
        return q;
    endfunction

    function automatic byte_q_t fill_ascii(input int n);
        byte_q_t q;
        repeat (n) q = {q, 8'($urandom_range(8'h21, 8'h7E))};
        return q;
    endfunction

    // Builds a well-formed name with random content, then plants one fault in
    // part of them: whitespace at an end, a control or DEL, an overlong form,
    // a surrogate, a code point past the top, a cut-off sequence, a broken
    // continuation, a stray byte, plain noise, an empty or an overlong name.
    function automatic byte_q_t build_name();
        byte_q_t     q;
        byte_q_t     t;
        logic [20:0] cp;
        logic [7:0]  b;
        int          kind;
        int          glyphs;
        int          len;
        int          idx;
        kind   = $urandom_range(0, 99);
        glyphs = $urandom_range(1, (limit_now < 8) ? 2 : 6);
        for (int i = 0; i < glyphs; i++)
        begin
            // Inner positions may hold whitespace or its close neighbours.
            idx = $urandom_range(0, 7);
            if (i != 0 && i != glyphs - 1 && idx == 0)
                cp = BLANKS[$urandom_range(0, 11)];
            else if (i != 0 && i != glyphs - 1 && idx == 1)
                cp = BLANKS[$urandom_range(0, 11)] + 21'd1;
            else
                cp = pick_glyph();
            q = {q, encode(cp, 0)};
        end

        if (kind < 55)
        begin
            // Left well formed.
        end
        else if (kind < 62)
        begin
            t = encode(BLANKS[$urandom_range(0, 11)], 0);
            case ($urandom_range(0, 2))
                0:       q = {t, q};
                1:       q = {q, t};
                default: q = {t, q, t};
            endcase
        end
        else if (kind < 67)
        begin
            cp = ($urandom_range(0, 3) == 0) ? CODE_DEL : 21'($urandom_range(0, 21'h1F));
            q = splice(q, encode(cp, 1));
        end
        else if (kind < 72)
        begin
            len = $urandom_range(2, 4);
            case (len)
                2:       cp = 21'($urandom_range(0, 21'h7F));
                3:       cp = 21'($urandom_range(0, 21'h7FF));
                default: cp = 21'($urandom_range(0, 21'hFFFF));
            endcase
            q = splice(q, encode(cp, len));
        end
        else if (kind < 76)
        begin
            q = splice(q, encode(21'($urandom_range(SURR_LO, SURR_HI)), 3));
        end
        else if (kind < 79)
        begin
            q = splice(q, encode(21'($urandom_range(21'h110000, 21'h13FFFF)), 4));
        end
        else if (kind < 84)
        begin
            t = encode(21'($urandom_range(21'h80, 21'h10FFFF)), 0);
            repeat ($urandom_range(1, t.size() - 1)) void'(t.pop_back());
            q = {q, t};
        end
        else if (kind < 88)
        begin
            t   = encode(21'($urandom_range(21'h80, 21'h10FFFF)), 0);
            idx = $urandom_range(1, t.size() - 1);
            b   = 8'($urandom);
            if (b[7:6] == 2'b10)
                b[6] = 1'b1;
            t[idx] = b;
            q = splice(q, t);
        end
        else if (kind < 91)
        begin
            case ($urandom_range(0, 2))
                0:       b = 8'($urandom_range(8'h80, 8'hBF));
                1:       b = 8'($urandom_range(8'hC0, 8'hC1));
                default: b = 8'($urandom_range(8'hF5, 8'hFF));
            endcase
            q = splice(q, '{b});
        end
        else if (kind < 95)
        begin
            q.delete();
            repeat ($urandom_range(1, 8)) q = {q, 8'($urandom)};
        end
        else if (kind < 97)
        begin
            q.delete();
        end
        else if (limit_now <= 8'd40)
        begin
            q = fill_ascii(int'(limit_now) + $urandom_range(1, 3));
        end
        return q;
    endfunction

    // ---------------------------------------------------------------- phases

    // Names right at the limit and just past it, where that stays cheap.
    task automatic boundary_names();
        if (limit_now == 8'd255)
        begin
            send_name(fill_ascii(255));
            send_name(fill_ascii(257));
        end
        else if (limit_now <= 8'd40)
        begin
            for (int n = int'(limit_now); n <= int'(limit_now) + 2; n++)
                if (n > 0)
                    send_name(fill_ascii(n));
        end
    endtask

    task automatic random_names(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
            send_name(build_name());
    endtask

    // Hand-picked names at the reset limit of 64 bytes.
    task automatic directed_names();
        byte_q_t none;
        send_name('{8'h41});                          // single letter, valid
        send_name(none);                              // empty name
        push_item(8'hA5, 1'b0, 1'b0);                 // no byte, not last: ignored
        send_name('{8'h7E});
        send_name('{8'hF4, 8'h8F, 8'hBF, 8'hBF});     // highest code point, valid
        send_name('{8'hE0, 8'h80, 8'hAF});            // overlong slash
        send_name('{8'hED, 8'hA0, 8'h80});            // surrogate
        send_name('{8'hF4, 8'h90, 8'h80, 8'h80});     // one past the top
        send_name('{8'hC2, 8'hA0});                   // lone no-break space
        send_name('{8'hE2, 8'h82});                   // cut short
        send_name('{8'hC3, 8'h41});                   // continuation missing
        send_name('{8'hFF});                          // stray byte
        push_item(8'h00, 1'b1, 1'b0);                 // NUL, then closed without a byte
        push_item(8'hFF, 1'b0, 1'b1);
        send_name('{8'h7F});                          // DEL
        bytes_sent++;
        names_sent++;
    endtask

    // ------------------------------------------------------------------ main

    initial
    begin
        int plan_limit  [PHASES];
        int plan_budget [PHASES];
        int plan_idle   [PHASES];

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        s_tlast   <= 1'b0;
        idle_pct     = 10;
        limit_now    = LIMIT_RESET;
        bytes_sent   = 0;
        names_sent   = 0;
        limits_tried = 1;

        // Limits run through the extremes; the last phase goes at full rate.
        // The two long names at the top limit take most of the items.
        plan_limit  = '{1, 255, 0, 2, $urandom_range(3, 16), $urandom_range(17, 254), 64};
        plan_budget = '{20, 20, 20, 20, 30, 30, 50};
        plan_idle   = '{10, 0, 25, 10, 25, 10, 0};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_names();
        for (int p = 0; p < PHASES; p++)
        begin
            drain_verdicts();
            load_limit(8'(plan_limit[p]));
            idle_pct = plan_idle[p];
            boundary_names();
            random_names(plan_budget[p]);
        end
        drain_verdicts();

        $display("Sent %0d names in %0d byte items under %0d length limits",
                 names_sent, bytes_sent, limits_tried);
        $display("(0, 1, 2, 255 included); checked %0d verdicts, %0d of them valid names.",
                 verdicts_checked, verdicts_valid);
        if (mismatch_count == 0 && verdicts_waiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: utf8_name_validator.f
rtl/core/utf8nv_pkg.sv
rtl/core/utf8nv_step.sv
rtl/core/utf8nv_out.sv
rtl/core/utf8_name_validator.sv
sim/utf8_name_checker.sv
sim/utf8_name_validator_test.sv
